// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // per-cycle shift command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at the insert point, everything behind moves back
    logic del;  // close the slot at the match, everything behind moves forward
  } spq_ctl_t;

endpackage

// ===== rtl/spq_ifs.sv =====
interface spq_in_if #(
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  spq_pkg::op_t                 operation;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface spq_out_if #(
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
  logic                         valid;
  logic                         ready;
  spq_pkg::status_t             status;
  logic [CNT_W-1:0]             count;
  logic signed [VALUE_BITS-1:0] head_value;
  logic                         head_valid;

  modport source (output valid, output status, output count, output head_value,
                  output head_valid, input ready);
  modport sink   (input valid, input status, input count, input head_value,
                  input head_valid, output ready);
endinterface

// ===== rtl/sorted_priority_queue.sv =====
// Channel | Dir | Payload                                   | Handshake
// in_ch   | in  | operation, value                          | valid/ready
// out_ch  | out | status, count, head_value, head_valid     | valid/ready
//
// One request per cycle: the row of cells applies every insert or delete as it
// is accepted, and its result sits in the output register the next cycle.
// A new request is taken while that register is free or being drained, so
// back-to-back requests flow at one per cycle unless out_ch stalls.
// Reset (rst_n low, synchronous) empties the queue and drops any held result;
// entry storage is not cleared, only the count is.
module sorted_priority_queue #(
  parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input logic clk,
  input logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  // cell row: position 0 is the head (largest value)
  logic signed [VALUE_BITS-1:0] entry     [CAPACITY];
  logic signed [VALUE_BITS-1:0] entry_nxt [CAPACITY];
  logic [CAPACITY-1:0]          cond;
  logic [CAPACITY-1:0]          eq;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  spq_ctl_t          ctl;
  logic              accept;
  logic              full;
  logic              empty;
  logic              found;
  status_t           status;

  // output register
  logic                         out_valid_r;
  status_t                      status_r;
  logic [CNT_W-1:0]             count_r;
  logic signed [VALUE_BITS-1:0] head_r;
  logic                         head_valid_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (in_ch.value),
      .cnt        (cnt_r),
      .prev_entry ((i == 0) ? in_ch.value : entry[(i == 0) ? 0 : i - 1]),
      .prev_cond  ((i == 0) ? 1'b0 : cond[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == CAPACITY - 1) ? in_ch.value
                                       : entry[(i == CAPACITY - 1) ? i : i + 1]),
      .entry      (entry[i]),
      .cond       (cond[i]),
      .eq         (eq[i]),
      .entry_nxt  (entry_nxt[i])
    );
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Entries are sorted, so any match means the first slot where
  // value >= entry holds the head-most equal entry.
  always_comb begin
    full    = cnt_r == CNT_W'(CAPACITY);
    empty   = cnt_r == '0;
    found   = |eq;
    ctl.ins = accept && (in_ch.operation == OP_INSERT) && !full;
    ctl.del = accept && (in_ch.operation == OP_DELETE) && found;

    if (in_ch.operation == OP_INSERT) begin
      status = full ? ST_FULL : ST_OK;
    end else if (empty) begin
      status = ST_EMPTY;
    end else begin
      status = found ? ST_OK : ST_NOT_FOUND;
    end

    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with the post-operation head
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= status;
      count_r      <= cnt_nxt;
      head_valid_r <= cnt_nxt != '0;
      head_r       <= (cnt_nxt != '0) ? entry_nxt[0] : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.count      = count_r;
  assign out_ch.head_value = head_r;
  assign out_ch.head_valid = head_valid_r;

endmodule

// ===== rtl/spq_cell.sv =====
module spq_cell #(
  parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = $clog2(spq_pkg::CAPACITY_DEF + 1),
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  spq_pkg::spq_ctl_t            ctl,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic [CNT_W-1:0]             cnt,
  input  logic signed [VALUE_BITS-1:0] prev_entry,
  input  logic                         prev_cond,
  input  logic signed [VALUE_BITS-1:0] next_entry,
  output logic signed [VALUE_BITS-1:0] entry,
  output logic                         cond,
  output logic                         eq,
  output logic signed [VALUE_BITS-1:0] entry_nxt
);
  import spq_pkg::*;

  logic signed [VALUE_BITS-1:0] entry_r;
  logic                         occ;

  // empty slots count as "value >= entry" so cond stays a thermometer
  always_comb begin
    occ  = cnt > CNT_W'(IDX);
    cond = !occ || (value >= entry_r);
    eq   = occ && (entry_r == value);
    if (ctl.ins) begin
      if (prev_cond) begin
        entry_nxt = prev_entry;
      end else if (cond) begin
        entry_nxt = value;
      end else begin
        entry_nxt = entry_r;
      end
    end else if (ctl.del) begin
      entry_nxt = cond ? next_entry : entry_r;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
